FILE: design/psts_pkg.sv
// ----------------------------------------------------------------------------
// psts_pkg: shared types for the periodic task tick scheduler
// Operation codes and the transaction word that travels down the slot chain.
// ----------------------------------------------------------------------------
package psts_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned ID_W    = 3;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned MASK_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_SUSPEND = 3'd2,
        OP_RESUME  = 3'd3,
        OP_KILL    = 3'd4
    } op_t;

    // One transaction as it moves from cell to cell
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] first_delay;
        logic [MASK_W-1:0] fired_mask;
    } psts_cmd_t;

endpackage

FILE: design/psts_cell.sv
// ----------------------------------------------------------------------------
// psts_cell: one task slot of the scheduler chain
// Holds one slot's state, applies the passing transaction to it and hands
// the transaction (with its fired bit merged in) to the next cell.
// ----------------------------------------------------------------------------
module psts_cell
    import psts_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      enable,
    input  psts_cmd_t cmd_in,
    output psts_cmd_t cmd_out
);

    localparam bit              SHOWN   = (INDEX < MASK_W);
    localparam logic [ID_W-1:0] BIT_POS = ID_W'(INDEX % MASK_W);

    logic              used_reg,   used_next;
    logic              ready_reg,  ready_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0] count_reg,  count_next;
    psts_cmd_t         cmd_reg,    cmd_next;
    logic              hit;

    assign hit = (32'(cmd_in.task_id) == INDEX);

    always_comb begin
        used_next   = used_reg;
        ready_next  = ready_reg;
        period_next = period_reg;
        count_next  = count_reg;
        cmd_next    = cmd_in;
        if (cmd_in.valid) begin
            unique case (cmd_in.op)
                OP_TICK: begin
                    if (used_reg && ready_reg) begin
                        if (count_reg == '0) begin
                            // reload wraps to all ones for a zero period
                            count_next = period_reg - TIME_W'(1);
                            if (SHOWN) begin
                                cmd_next.fired_mask[BIT_POS] = 1'b1;
                            end
                        end else begin
                            count_next = count_reg - TIME_W'(1);
                        end
                    end
                end
                OP_CREATE: begin
                    if (hit && !used_reg) begin
                        used_next   = 1'b1;
                        ready_next  = 1'b1;
                        period_next = cmd_in.period;
                        count_next  = cmd_in.first_delay;
                    end
                end
                OP_SUSPEND: begin
                    if (hit) begin
                        ready_next = 1'b0;
                    end
                end
                OP_RESUME: begin
                    if (hit) begin
                        ready_next = 1'b1;
                    end
                end
                OP_KILL: begin
                    if (hit) begin
                        used_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            cmd_reg.valid <= 1'b0;
        end else if (enable) begin
            used_reg   <= used_next;
            ready_reg  <= ready_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign cmd_out = cmd_reg;

endmodule

FILE: design/periodic_task_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top: time-triggered periodic task scheduler
// Table of task slots kept in a chain of cells, one cell per slot.
// ----------------------------------------------------------------------------
// Each accepted transaction walks the chain of TASKS slot cells, one cell per
// cycle, and every cell applies it to its own slot. One transaction is in the
// chain at a time, so the next one is taken only after the last has left the
// chain; a tick leaves its fired mask in the output register at the end of
// the chain, where it may wait for m_ready while the next transaction is
// already accepted. Only ticks produce a result; create, suspend, resume,
// kill and unused op codes produce none.
// Slots beyond eight cannot be addressed and never fire.
module periodic_task_tick_scheduler_top
    import psts_pkg::*;
#(
    parameter int unsigned TASKS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [ID_W-1:0]   s_task_id,
    input  logic [TIME_W-1:0] s_period,
    input  logic [TIME_W-1:0] s_first_delay,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [MASK_W-1:0] m_fired_mask
);

    psts_cmd_t         chain [TASKS+1];
    psts_cmd_t         head;
    logic [TASKS-1:0]  chain_valid;
    psts_cmd_t         tail;
    logic              enable;
    logic              tail_tick;
    logic              busy_reg,  busy_next;
    logic              mvld_reg,  mvld_next;
    logic [MASK_W-1:0] mask_reg,  mask_next;

    assign s_ready = !busy_reg;

    always_comb begin
        head.valid       = s_valid && !busy_reg;
        head.op          = op_t'(s_op);
        head.task_id     = s_task_id;
        head.period      = s_period;
        head.first_delay = s_first_delay;
        head.fired_mask  = '0;
    end

    assign chain[0] = head;

    for (genvar g = 0; g < TASKS; g++) begin : g_cell
        psts_cell #(
            .INDEX(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .enable  (enable),
            .cmd_in  (chain[g]),
            .cmd_out (chain[g+1])
        );
        assign chain_valid[g] = chain[g+1].valid;
    end

    assign tail      = chain[TASKS];
    assign tail_tick = tail.valid && (tail.op == OP_TICK);
    // hold the chain while a finished tick cannot reach the output register
    assign enable    = !(tail_tick && mvld_reg && !m_ready);

    always_comb begin
        busy_next = busy_reg;
        mvld_next = mvld_reg;
        mask_next = mask_reg;
        if (m_ready) begin
            mvld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            busy_next = 1'b1;
        end else if (tail.valid && enable) begin
            busy_next = 1'b0;
        end
        if (tail_tick && enable) begin
            mvld_next = 1'b1;
            mask_next = tail.fired_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mvld_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mvld_reg <= mvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
    end

    assign m_valid      = mvld_reg;
    assign m_fired_mask = mask_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_single_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn) $onehot0(chain_valid)
    ) else $error("more than one transaction in the slot chain");

    a_idle_when_ready: assert property (
        @(posedge aclk) disable iff (!aresetn) s_ready |-> (chain_valid == '0)
    ) else $error("input ready while the chain is busy");

    a_result_from_tick: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(tail_tick && enable)
    ) else $error("result produced without a tick leaving the chain");

endmodule
